// File: hdl/tsac_pkg.sv
// Shared types and constants for the touch sample averaging and calibration block.
// Holds the sequencer state and config index types, the divider structs and fixed widths.
// No dependencies.
package tsac_pkg;

	localparam int unsigned RAW_W    = 16;
	localparam int unsigned PX_W     = 12;
	localparam int unsigned PY_W     = 8;
	localparam int unsigned CFG_IX_W = 3;
	// Divider operand widths: the widest dividend is the scaled product, 16 x 12 bits.
	localparam int unsigned DIV_NW   = RAW_W + PX_W;
	localparam int unsigned DIV_DW   = RAW_W;

	localparam logic [PY_W-1:0] Y_FLIP_BASE = 8'd240;

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_RAW_X_MIN = 3'd0,
		CFG_RAW_X_MAX = 3'd1,
		CFG_RAW_Y_MIN = 3'd2,
		CFG_RAW_Y_MAX = 3'd3,
		CFG_X_SPAN    = 3'd4,
		CFG_Y_SPAN    = 3'd5
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AX_GO,
		ST_AX_WAIT,
		ST_AY_GO,
		ST_AY_WAIT,
		ST_MX,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_MY,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

endpackage

// File: hdl/touch_sample_average_calibrate_top.sv
// Top level of the touch sample averaging and linear calibration block.
// Depends on tsac_pkg and instantiates tsac_div, the shared iterative divider.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   input   | in_valid / in_ready  | pressed, x_sample, y_sample
//   output  | out_valid / out_ready| touch_valid, touch_x, touch_y
//   config  | cfg_we (no wait)     | cfg_index, cfg_data
//
// A pressed item that does not close a burst is added to the sums and leaves in_ready high.
// An item that closes a burst keeps in_ready low through four divisions on the one shared
// divider (start, 28 steps, done each), a multiply per axis and a hand-off.
// A release with no samples skips to the hand-off. Reset clears the sums, the count,
// the sequencer and the output valid, and loads the default calibration window. A stalled
// output holds its result; items are still taken, and only the next result waits for it.
module touch_sample_average_calibrate_top #(
	parameter int unsigned MAX_SAMPLES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              pressed,
	input  logic [tsac_pkg::RAW_W-1:0]        x_sample,
	input  logic [tsac_pkg::RAW_W-1:0]        y_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              touch_valid,
	output logic [tsac_pkg::PX_W-1:0]         touch_x,
	output logic [tsac_pkg::PY_W-1:0]         touch_y,
	input  logic                              cfg_we,
	input  logic [tsac_pkg::CFG_IX_W-1:0]     cfg_index,
	input  logic [tsac_pkg::RAW_W-1:0]        cfg_data
);
	import tsac_pkg::*;

	// Count must hold MAX_SAMPLES itself; the sums grow by the same number of bits.
	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUM_W = RAW_W + CNT_W;

	// Calibration registers
	logic [RAW_W-1:0] raw_x_min_q, raw_x_max_q, raw_y_min_q, raw_y_max_q;
	logic [PX_W-1:0]  x_span_q;
	logic [PY_W-1:0]  y_span_q;

	// Burst state
	logic [SUM_W-1:0] x_sum_q, y_sum_q;
	logic [CNT_W-1:0] cnt_q;

	// Sequencer and datapath
	state_t           state_q, state_d;
	logic [RAW_W-1:0] avg_x_q, avg_y_q;
	logic [DIV_NW-1:0] prod_q;
	logic [PX_W-1:0]  res_x_q;
	logic [PY_W-1:0]  res_y_q;
	logic             res_valid_q;

	// Output register
	logic             out_valid_q;
	logic             out_touch_valid_q;
	logic [PX_W-1:0]  out_x_q;
	logic [PY_W-1:0]  out_y_q;

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic             accept;
	logic             burst_full;
	logic             burst_end;
	logic             empty_release;
	logic             slot_free;
	logic             x_degen, y_degen;
	logic             axis_y;
	logic [RAW_W-1:0] lo, hi, avg, clamped, diff;
	logic [PX_W-1:0]  span;
	logic [PY_W-1:0]  sy;
	logic [PY_W-1:0]  flipped;

	assign accept        = in_valid && in_ready;
	assign burst_full    = pressed && ((cnt_q + CNT_W'(1)) == CNT_W'(MAX_SAMPLES));
	assign burst_end     = burst_full || (!pressed && (cnt_q != '0));
	assign empty_release = !pressed && (cnt_q == '0);
	assign slot_free     = !out_valid_q || out_ready;

	assign x_degen = raw_x_max_q <= raw_x_min_q;
	assign y_degen = raw_y_max_q <= raw_y_min_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_x_min_q <= RAW_W'(3400);
			raw_x_max_q <= RAW_W'(29000);
			raw_y_min_q <= RAW_W'(3300);
			raw_y_max_q <= RAW_W'(30000);
			x_span_q    <= PX_W'(320);
			y_span_q    <= PY_W'(240);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAW_X_MIN: raw_x_min_q <= cfg_data;
				CFG_RAW_X_MAX: raw_x_max_q <= cfg_data;
				CFG_RAW_Y_MIN: raw_y_min_q <= cfg_data;
				CFG_RAW_Y_MAX: raw_y_max_q <= cfg_data;
				CFG_X_SPAN:    x_span_q    <= cfg_data[PX_W-1:0];
				CFG_Y_SPAN:    y_span_q    <= cfg_data[PY_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (burst_end) begin
						state_d = ST_AX_GO;
					end else if (empty_release) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_AX_GO:   state_d = ST_AX_WAIT;
			ST_AX_WAIT: if (div_rsp.done) state_d = ST_AY_GO;
			ST_AY_GO:   state_d = ST_AY_WAIT;
			ST_AY_WAIT: if (div_rsp.done) state_d = ST_MX;
			ST_MX:      state_d = ST_DX_GO;
			ST_DX_GO:   state_d = ST_DX_WAIT;
			ST_DX_WAIT: if (div_rsp.done) state_d = ST_MY;
			ST_MY:      state_d = ST_DY_GO;
			ST_DY_GO:   state_d = ST_DY_WAIT;
			ST_DY_WAIT: if (div_rsp.done) state_d = ST_DONE;
			ST_DONE:    if (slot_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------- outputs
	// Raise in_ready in idle, start the divisions and pick the axis: Y in ST_MY and ST_DY_GO.
	always_comb begin
		in_ready    = 1'b0;
		axis_y      = 1'b0;
		div_req     = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_AX_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'(x_sum_q);
				div_req.den   = DIV_DW'(cnt_q);
			end
			ST_AY_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'(y_sum_q);
				div_req.den   = DIV_DW'(cnt_q);
			end
			ST_DX_GO: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q;
				div_req.den   = raw_x_max_q - raw_x_min_q;
			end
			ST_MY: begin
				axis_y = 1'b1;
			end
			ST_DY_GO: begin
				axis_y        = 1'b1;
				div_req.start = 1'b1;
				div_req.num   = prod_q;
				div_req.den   = raw_y_max_q - raw_y_min_q;
			end
			default: ;
		endcase
	end

	tsac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Clamp the average into its window and take the offset from the zero point.
	assign lo      = axis_y ? raw_y_min_q : raw_x_min_q;
	assign hi      = axis_y ? raw_y_max_q : raw_x_max_q;
	assign avg     = axis_y ? avg_y_q : avg_x_q;
	assign span    = axis_y ? PX_W'(y_span_q) : x_span_q;
	assign clamped = (avg < lo) ? lo : ((avg > hi) ? hi : avg);
	assign diff    = clamped - lo;

	// Flip Y about the base, saturating at zero.
	assign sy      = div_rsp.quo[PY_W-1:0];
	assign flipped = (sy > Y_FLIP_BASE) ? '0 : (Y_FLIP_BASE - sy);

	// ---------------------------------------------------------------- burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			cnt_q   <= '0;
		end else if (accept && pressed) begin
			x_sum_q <= x_sum_q + SUM_W'(x_sample);
			y_sum_q <= y_sum_q + SUM_W'(y_sample);
			cnt_q   <= cnt_q + CNT_W'(1);
		end else if (state_q == ST_DONE && slot_free) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			cnt_q   <= '0;
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_AX_WAIT && div_rsp.done) begin
			avg_x_q <= div_rsp.quo[RAW_W-1:0];
		end
		if (state_q == ST_AY_WAIT && div_rsp.done) begin
			avg_y_q <= div_rsp.quo[RAW_W-1:0];
		end
		if (state_q == ST_MX || state_q == ST_MY) begin
			prod_q <= DIV_NW'(diff) * DIV_NW'(span);
		end
		if (state_q == ST_DX_WAIT && div_rsp.done) begin
			res_x_q <= x_degen ? '0 : div_rsp.quo[PX_W-1:0];
		end
		if (state_q == ST_DY_WAIT && div_rsp.done) begin
			res_y_q <= y_degen ? '0 : flipped;
		end
		// Empty release: give an invalid result with zero coordinates.
		if (accept && empty_release) begin
			res_x_q <= '0;
			res_y_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= !empty_release;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_touch_valid_q <= res_valid_q;
			out_x_q           <= res_x_q;
			out_y_q           <= res_y_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign touch_valid = out_touch_valid_q;
	assign touch_x     = out_x_q;
	assign touch_y     = out_y_q;

endmodule

// File: hdl/tsac_div.sv
// Restoring divider, one quotient bit per cycle, for the touch calibration block.
// Depends on tsac_pkg for operand widths and the request and response structs.
module tsac_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tsac_pkg::div_req_t req,
	output tsac_pkg::div_rsp_t rsp
);
	import tsac_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;

	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift the dividend out at the top and the quotient bits in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for touch_sample_average_calibrate_top.
// Runs directed and random touch bursts with random idling and calibration changes, and
// compares each result with its own prediction. Depends on tsac_pkg and the top level.
module testbench;
	import tsac_pkg::*;

	localparam int unsigned BURST_LIMIT    = 16;
	// Allow generous settling after a burst end before a register write.
	localparam int unsigned SETTLE_CYCLES  = 200;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned HOLD_OFF_LONG  = 400;

	typedef struct {
		bit            valid;
		bit [PX_W-1:0] x;
		bit [PY_W-1:0] y;
	} touch_point_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                pressed;
	logic [RAW_W-1:0]    x_sample;
	logic [RAW_W-1:0]    y_sample;
	logic                out_valid;
	logic                out_ready;
	logic                touch_valid;
	logic [PX_W-1:0]     touch_x;
	logic [PY_W-1:0]     touch_y;
	logic                cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [RAW_W-1:0]    cfg_data;

	// Predictor copy of the calibration registers, loaded with the reset defaults.
	bit [RAW_W-1:0] cal_x_min  = 16'd3400;
	bit [RAW_W-1:0] cal_x_max  = 16'd29000;
	bit [RAW_W-1:0] cal_y_min  = 16'd3300;
	bit [RAW_W-1:0] cal_y_max  = 16'd30000;
	bit [PX_W-1:0]  cal_x_span = 12'd320;
	bit [PY_W-1:0]  cal_y_span = 8'd240;

	// Predictor copy of the burst accumulator.
	bit [19:0]   sum_x;
	bit [19:0]   sum_y;
	int unsigned n_taken;

	touch_point_t expected_points[$];
	int unsigned  errors;
	int unsigned  items_sent;
	bit           full_speed;
	int unsigned  hold_off_cycles;
	int unsigned  quiet_cycles;

	touch_sample_average_calibrate_top #(
		.MAX_SAMPLES(BURST_LIMIT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pressed    (pressed),
		.x_sample   (x_sample),
		.y_sample   (y_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.touch_valid(touch_valid),
		.touch_x    (touch_x),
		.touch_y    (touch_y),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Clamp the average into its window and map it linearly onto 0..span.
	function automatic longint unsigned map_to_screen(longint unsigned avg,
			longint unsigned lo, longint unsigned hi, longint unsigned span);
		longint unsigned num;
		if (hi <= lo)
			return 0;
		if (avg < lo)
			avg = lo;
		if (avg > hi)
			avg = hi;
		num = (avg - lo) * span;
		return num / (hi - lo);
	endfunction

	// Average the burst, calibrate both axes, flip Y and clear the accumulator.
	function automatic touch_point_t close_burst();
		touch_point_t    pt;
		longint unsigned scaled_y;
		pt.valid = 1'b1;
		pt.x = PX_W'(map_to_screen(sum_x / n_taken, cal_x_min, cal_x_max, cal_x_span));
		if (cal_y_max <= cal_y_min) begin
			pt.y = '0;
		end else begin
			scaled_y = map_to_screen(sum_y / n_taken, cal_y_min, cal_y_max, cal_y_span);
			// Saturate the flip: a scaled value past the base gives 0.
			pt.y = (scaled_y > Y_FLIP_BASE) ? '0 : PY_W'(Y_FLIP_BASE - scaled_y);
		end
		sum_x = '0;
		sum_y = '0;
		n_taken = 0;
		return pt;
	endfunction

	function automatic void predict_sample(bit down, bit [RAW_W-1:0] xs, bit [RAW_W-1:0] ys);
		touch_point_t pt;
		if (down) begin
			sum_x += xs;
			sum_y += ys;
			n_taken++;
			if (n_taken >= BURST_LIMIT)
				expected_points.push_back(close_burst());
		end else if (n_taken == 0) begin
			// Release with nothing collected: invalid point, zero coordinates.
			pt.valid = 1'b0;
			pt.x = '0;
			pt.y = '0;
			expected_points.push_back(pt);
		end else begin
			// Release closes the burst; its own readings are dropped.
			expected_points.push_back(close_burst());
		end
	endfunction

	// ------------------------------------------------------------------
	// Idling
	// ------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned idle_length();
		int unsigned r;
		if (full_speed)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offer one item, hold it until accepted, predict it, then idle for a random gap.
	task automatic send_item(bit down, bit [RAW_W-1:0] xs, bit [RAW_W-1:0] ys);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		pressed  <= down;
		x_sample <= xs;
		y_sample <= ys;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_sample(down, xs, ys);
		items_sent++;
		gap = idle_length();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every expected point has come out.
	task automatic drain_points();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	// Drain, then give the block time to finish any work that yields no point.
	task automatic wait_idle();
		drain_points();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic close_open_burst();
		if (n_taken != 0)
			send_item(1'b0, RAW_W'($urandom), RAW_W'($urandom));
	endtask

	// Hold the write enable high across consecutive writes; the caller lowers it.
	task automatic write_register(cfg_index_t idx, bit [RAW_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_RAW_X_MIN: cal_x_min = value;
			CFG_RAW_X_MAX: cal_x_max = value;
			CFG_RAW_Y_MIN: cal_y_min = value;
			CFG_RAW_Y_MAX: cal_y_max = value;
			CFG_X_SPAN:    cal_x_span = value[PX_W-1:0];
			CFG_Y_SPAN:    cal_y_span = value[PY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_calibration(bit [RAW_W-1:0] x_lo, bit [RAW_W-1:0] x_hi,
			bit [RAW_W-1:0] y_lo, bit [RAW_W-1:0] y_hi,
			bit [PX_W-1:0] x_span, bit [PY_W-1:0] y_span);
		close_open_burst();
		wait_idle();
		write_register(CFG_RAW_X_MIN, x_lo);
		write_register(CFG_RAW_X_MAX, x_hi);
		write_register(CFG_RAW_Y_MIN, y_lo);
		write_register(CFG_RAW_Y_MAX, y_hi);
		write_register(CFG_X_SPAN, RAW_W'(x_span));
		write_register(CFG_Y_SPAN, RAW_W'(y_span));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_calibration();
		bit [RAW_W-1:0] x_lo, x_hi, y_lo, y_hi;
		x_lo = RAW_W'($urandom_range(0, 30000));
		x_hi = RAW_W'($urandom_range(x_lo + 1, 65535));
		y_lo = RAW_W'($urandom_range(0, 30000));
		y_hi = RAW_W'($urandom_range(y_lo + 1, 65535));
		// Now and then collapse or invert the X window, the Y window or both.
		if ($urandom_range(0, 7) == 0)
			x_hi = RAW_W'($urandom_range(0, x_lo));
		if ($urandom_range(0, 7) == 0)
			y_hi = RAW_W'($urandom_range(0, y_lo));
		set_calibration(x_lo, x_hi, y_lo, y_hi,
			PX_W'($urandom_range(1, 4095)), PY_W'($urandom_range(1, 240)));
	endtask

	// ------------------------------------------------------------------
	// Stimulus shaping
	// ------------------------------------------------------------------

	function automatic bit [RAW_W-1:0] pick_centre(bit [RAW_W-1:0] lo, bit [RAW_W-1:0] hi);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return RAW_W'($urandom);
			default: return RAW_W'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic bit [RAW_W-1:0] jitter(bit [RAW_W-1:0] centre, int spread);
		int v;
		v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return RAW_W'(v);
	endfunction

	// Mostly realistic bursts around a touch point, with stray releases, full bursts
	// that end at the limit and bursts left open into the next one.
	task automatic random_bursts(int unsigned n_items);
		int unsigned    target, r, len, spread;
		bit [RAW_W-1:0] cx, cy;
		target = items_sent + n_items;
		while (items_sent < target) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				send_item(1'b0, RAW_W'($urandom), RAW_W'($urandom));
			end else begin
				len = (r < 3) ? BURST_LIMIT : $urandom_range(1, 24);
				cx = pick_centre(cal_x_min, cal_x_max);
				cy = pick_centre(cal_y_min, cal_y_max);
				spread = ($urandom_range(0, 3) == 0) ? 4000 : 64;
				for (int unsigned i = 0; i < len; i++) begin
					if ($urandom_range(0, 15) == 0)
						send_item(1'b1, RAW_W'($urandom), RAW_W'($urandom));
					else
						send_item(1'b1, jitter(cx, spread), jitter(cy, spread));
				end
				if (r >= 3 && $urandom_range(0, 9) != 0)
					send_item(1'b0, RAW_W'($urandom), RAW_W'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset window: empty release, readings at both raw extremes, release data dropped.
	task automatic test_reset_defaults();
		send_item(1'b0, 16'hFFFF, 16'h0000);
		send_item(1'b1, 16'h0000, 16'h0000);
		send_item(1'b0, 16'hFFFF, 16'hFFFF);
		send_item(1'b1, 16'hFFFF, 16'hFFFF);
		send_item(1'b0, 16'h0000, 16'h0000);
	endtask

	// Burst closed by the sample limit rather than a release.
	task automatic test_full_burst();
		repeat (BURST_LIMIT)
			send_item(1'b1, RAW_W'($urandom), RAW_W'($urandom));
	endtask

	// Collapsed and inverted windows, zero X span and a Y span past the flip base.
	task automatic test_special_windows();
		set_calibration(16'd5000, 16'd5000, 16'd200, 16'd100, 12'd320, 8'd240);
		send_item(1'b1, RAW_W'($urandom), RAW_W'($urandom));
		send_item(1'b0, RAW_W'($urandom), RAW_W'($urandom));
		set_calibration(16'd0, 16'd65535, 16'd0, 16'd1000, 12'd0, 8'd255);
		send_item(1'b1, RAW_W'($urandom), 16'hFFFF);
		send_item(1'b0, RAW_W'($urandom), RAW_W'($urandom));
	endtask

	// Widest windows, largest X span, a Y span at the flip base, no idling on either side.
	task automatic test_widest_window();
		set_calibration(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 12'd4095, 8'd240);
		full_speed = 1'b1;
		random_bursts(120);
		full_speed = 1'b0;
	endtask

	// One-count windows, Y at the top of the range, with spans of one.
	task automatic test_narrowest_window();
		set_calibration(16'd30000, 16'd30001, 16'd65534, 16'd65535, 12'd1, 8'd1);
		random_bursts(120);
	endtask

	task automatic test_random_calibration();
		repeat (4) begin
			random_calibration();
			random_bursts(110);
		end
	endtask

	// Hold the receiver off while short bursts keep coming, so the output register
	// fills and the block stops accepting items.
	task automatic test_output_backpressure();
		close_open_burst();
		drain_points();
		@(posedge clk);
		hold_off_cycles = HOLD_OFF_LONG;
		full_speed = 1'b1;
		repeat (20) begin
			send_item(1'b1, RAW_W'($urandom), RAW_W'($urandom));
			send_item(1'b0, RAW_W'($urandom), RAW_W'($urandom));
		end
		full_speed = 1'b0;
	endtask

	// Pause the sender until every expected point has arrived, then resume.
	task automatic test_sender_pause();
		random_bursts(20);
		drain_points();
		random_bursts(20);
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Receiver: random stalls, or a long hold-off when a test asks for one.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = idle_length();
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Compare every accepted point with the oldest prediction.
	always @(posedge clk) begin : point_check
		touch_point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch("point with nothing expected, touch_x", touch_x, 0);
			end else begin
				want = expected_points.pop_front();
				if (touch_valid !== want.valid)
					report_mismatch("touch_valid", touch_valid, want.valid);
				if (touch_x !== want.x)
					report_mismatch("touch_x", touch_x, want.x);
				if (touch_y !== want.y)
					report_mismatch("touch_y", touch_y, want.y);
			end
		end
	end

	// Watchdog: end the run once nothing has been accepted for too long.
	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("touch_sample_average_calibrate_top test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : main_sequence
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pressed   = 1'b0;
		x_sample  = '0;
		y_sample  = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sum_x     = '0;
		sum_y     = '0;
		n_taken   = 0;
		errors    = 0;
		items_sent = 0;
		full_speed = 1'b0;
		hold_off_cycles = 0;

		// Hold reset, then release it away from the sampling edge.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_full_burst();
		test_special_windows();
		test_widest_window();
		test_narrowest_window();
		test_output_backpressure();
		test_sender_pause();
		test_random_calibration();

		// Flush the last open burst, drain, and watch for stray points.
		close_open_burst();
		wait_idle();

		if (errors == 0)
			$display("touch_sample_average_calibrate_top test passed");
		else
			$display("touch_sample_average_calibrate_top test failed");
		$finish;
	end

endmodule
